FILE: src/nfrt_pkg.sv
// Package: shared constants, codes and types of the newest-first route table.
`timescale 1ns / 1ps
package nfrt_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_IFACE_BITS = 16;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2,
		STATUS_RSVD = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_SHIFT = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

endpackage

FILE: src/nfrt_entry_ram.sv
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module nfrt_entry_ram #(
	parameter int DEPTH = nfrt_pkg::DEF_CAPACITY,
	parameter int WIDTH = nfrt_pkg::DEF_KEY_BITS + nfrt_pkg::DEF_IFACE_BITS,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import nfrt_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: src/newest_first_route_table_core.sv
// Top level: newest-first exact-match route table over a single entry memory.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_ready  | operation, route_key, new_iface
//  out     | output    | out_valid / out_ready| status, found_iface
//
// Entries sit oldest-first in memory slots 0..n-1; a fill count marks the valid ones.
// Add and a short-cut miss/full go straight to the response state. Lookup scans entries
// newest first, one memory read per cycle; delete then moves each newer entry down a slot.
// Reset clears the fill count and registers, not the memory; no clearing pass. A stalled result
// holds the block in its response state; the next word is taken once the output register is loaded.
`timescale 1ns / 1ps
module newest_first_route_table_core #(
	parameter int CAPACITY   = nfrt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = nfrt_pkg::DEF_KEY_BITS,
	parameter int IFACE_BITS = nfrt_pkg::DEF_IFACE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [nfrt_pkg::OP_W-1:0]     operation,
	input  logic [KEY_BITS-1:0]           route_key,
	input  logic [IFACE_BITS-1:0]         new_iface,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nfrt_pkg::STATUS_W-1:0] status,
	output logic [nfrt_pkg::FOUND_W-1:0]  found_iface
);
	import nfrt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + IFACE_BITS;

	state_t              state_q;
	logic [CW-1:0]       n_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       rd_addr_q;
	status_t             res_status_q;
	logic [FOUND_W-1:0]  res_found_q;
	logic                out_valid_q;
	status_t             status_q;
	logic [FOUND_W-1:0]  found_q;

	logic [AW-1:0]         rd_addr;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [EW-1:0]         wdata;
	logic [EW-1:0]         rdata;
	logic [KEY_BITS-1:0]   rd_key;
	logic [IFACE_BITS-1:0] rd_iface;
	logic [FOUND_W+IFACE_BITS-1:0] iface_ext;
	logic [AW-1:0]         last_addr;
	logic                  hit;
	logic                  full;
	logic                  accept;

	assign rd_key    = rdata[EW-1:IFACE_BITS];
	assign rd_iface  = rdata[IFACE_BITS-1:0];
	assign iface_ext = {{FOUND_W{1'b0}}, rd_iface};
	assign last_addr = AW'(n_q - CW'(1));
	assign hit       = (rd_key == key_q);
	assign full      = (n_q == CW'(CAPACITY));
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	// read address for the entry compared or moved next cycle
	always_comb begin
		rd_addr = rd_addr_q;
		we      = 1'b0;
		waddr   = AW'(n_q);
		wdata   = {route_key, new_iface};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(operation)) inside
						OP_LOOKUP, OP_DELETE: rd_addr = last_addr;
						OP_ADD: we = !full;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (!hit && rd_addr_q != '0) begin
					rd_addr = rd_addr_q - AW'(1);
				end else if (hit && op_q == OP_DELETE && rd_addr_q != last_addr) begin
					rd_addr = rd_addr_q + AW'(1);
				end
			end
			ST_SHIFT: begin
				// close the gap: slot k moves down to k-1
				we    = 1'b1;
				waddr = rd_addr_q - AW'(1);
				wdata = rdata;
				if (rd_addr_q != last_addr) begin
					rd_addr = rd_addr_q + AW'(1);
				end
			end
			ST_RESP: ;
			default: ;
		endcase
	end

	nfrt_entry_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(EW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			op_q         <= OP_LOOKUP;
			key_q        <= '0;
			rd_addr_q    <= '0;
			res_status_q <= STATUS_MISS;
			res_found_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= STATUS_OK;
			found_q      <= '0;
		end else begin
			rd_addr_q <= rd_addr;
			// the response state owns the output register while it waits
			if (out_ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q        <= op_t'(operation);
						key_q       <= route_key;
						res_found_q <= '0;
						case (op_t'(operation)) inside
							OP_LOOKUP, OP_DELETE: begin
								res_status_q <= STATUS_MISS;
								state_q      <= (n_q != '0) ? ST_SCAN : ST_RESP;
							end
							OP_ADD: begin
								state_q <= ST_RESP;
								if (full) begin
									res_status_q <= STATUS_FULL;
								end else begin
									res_status_q <= STATUS_OK;
									n_q          <= n_q + CW'(1);
								end
							end
							default: begin
								res_status_q <= STATUS_MISS;
								state_q      <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						res_status_q <= STATUS_OK;
						if (op_q == OP_LOOKUP) begin
							res_found_q <= iface_ext[FOUND_W-1:0];
							state_q     <= ST_RESP;
						end else if (rd_addr_q == last_addr) begin
							n_q     <= n_q - CW'(1);
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SHIFT;
						end
					end else if (rd_addr_q == '0) begin
						state_q <= ST_RESP;
					end
				end
				ST_SHIFT: begin
					if (rd_addr_q == last_addr) begin
						n_q     <= n_q - CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						found_q     <= res_found_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_iface = found_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_ADD && !full) |=> (n_q == $past(n_q) + CW'(1)))
		else $error("add did not grow the table");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT || state_q == ST_SCAN) |-> (n_q != '0))
		else $error("scan or shift on an empty table");

	a_found_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q != STATUS_RSVD &&
			(found_q == '0 || status_q == STATUS_OK)))
		else $error("bad result word");

endmodule
